### hdl/siq_pkg.sv
// Shared types, opcodes and status codes of the sorted insert queue.
// No dependencies; used by siq_cell and sorted_insert_queue.
`timescale 1ns / 1ps

package siq_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PAY_W     = 32;
  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SORTED = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                    ins;     // insert taking place this cycle
    logic                    sorted;  // insert goes by key order
    logic                    rem;     // head removal taking place this cycle
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } ctl_t;

endpackage

### hdl/siq_cell.sv
// One queue slot: holds a key and payload, takes the new entry, its left
// neighbor's entry on insert, or its right neighbor's entry on removal.
// Depends on siq_pkg.
`timescale 1ns / 1ps

module siq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                            clk,
  input  siq_pkg::ctl_t                   ctl,
  input  logic                            valid,
  input  logic                            shift_in,
  input  logic signed [siq_pkg::KEY_W-1:0] prev_key,
  input  logic        [siq_pkg::PAY_W-1:0] prev_payload,
  input  logic signed [siq_pkg::KEY_W-1:0] next_key,
  input  logic        [siq_pkg::PAY_W-1:0] next_payload,
  output logic                            shift_out,
  output logic signed [siq_pkg::KEY_W-1:0] key_r,
  output logic        [siq_pkg::PAY_W-1:0] payload_r
);

  logic found;

  // The head goes behind an equal key; later slots go in front of one.
  always_comb begin
    if (!valid) begin
      found = 1'b1;
    end else if (!ctl.sorted) begin
      found = 1'b0;
    end else if (IS_HEAD) begin
      found = ctl.key < key_r;
    end else begin
      found = !(key_r < ctl.key);
    end
  end

  assign shift_out = shift_in || found;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (shift_in) begin
        key_r     <= prev_key;
        payload_r <= prev_payload;
      end else if (found) begin
        key_r     <= ctl.key;
        payload_r <= ctl.payload;
      end
    end else if (ctl.rem) begin
      key_r     <= next_key;
      payload_r <= next_payload;
    end
  end

endmodule

### hdl/sorted_insert_queue.sv
// Top level of the sorted insert queue: a row of siq_cell slots with a
// fill count and a registered result stage. Depends on siq_pkg, siq_cell.
`timescale 1ns / 1ps

// Ordered queue of DEPTH key/payload entries. Each input item appends,
// inserts by key or removes the head, and yields exactly one result item,
// which appears in the output register the cycle after the item is taken.
// One item is accepted every cycle as long as the result side keeps up;
// the input stalls only while a result waits unread. All slots compare the
// new key against their own in parallel, and a find-and-shift signal ripples
// through the DEPTH cells, which sets the longest path. Inserting into a
// full queue leaves it unchanged with status full; removing from an empty
// one gives status empty and zero key and payload.
module sorted_insert_queue #(
  parameter int unsigned DEPTH = siq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], payload [63:32]
  input  logic [1:0]  in_tuser,   // opcode [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_key [31:0], out_payload [63:32],
                                  // is_empty [64], fill_level [69:65], zero
  output logic [1:0]  out_tuser   // status [1:0]
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic signed [siq_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic        [siq_pkg::PAY_W-1:0] opay_r, opay_nxt;
  logic [CW-1:0] ofill_r;

  logic in_accept, full, empty;
  siq_pkg::ctl_t ctl;

  logic signed [siq_pkg::KEY_W-1:0] cell_key [DEPTH];
  logic        [siq_pkg::PAY_W-1:0] cell_pay [DEPTH];
  logic [DEPTH:0]   shift;
  logic [DEPTH-1:0] valid;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign full      = count_r == CW'(DEPTH);
  assign empty     = count_r == '0;

  always_comb begin
    ctl         = '0;
    ctl.key     = in_tdata[siq_pkg::KEY_W-1:0];
    ctl.payload = in_tdata[63:32];
    status_nxt  = siq_pkg::ST_OK;
    okey_nxt    = '0;
    opay_nxt    = '0;
    count_nxt   = count_r;
    unique case (in_tuser) inside
      siq_pkg::OP_APPEND, siq_pkg::OP_SORTED: begin
        if (full) begin
          status_nxt = siq_pkg::ST_FULL;
        end else begin
          ctl.ins    = in_accept;
          ctl.sorted = in_tuser == siq_pkg::OP_SORTED;
          count_nxt  = count_r + CW'(1);
        end
      end
      siq_pkg::OP_REMOVE: begin
        if (empty) begin
          status_nxt = siq_pkg::ST_EMPTY;
        end else begin
          ctl.rem   = in_accept;
          okey_nxt  = cell_key[0];
          opay_nxt  = cell_pay[0];
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign shift[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [siq_pkg::KEY_W-1:0] pk, nk;
    logic        [siq_pkg::PAY_W-1:0] pp, np;

    assign valid[i] = CW'(i) < count_r;

    if (i == 0) begin : g_first
      assign pk = ctl.key;
      assign pp = ctl.payload;
    end else begin : g_mid
      assign pk = cell_key[i-1];
      assign pp = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nk = '0;
      assign np = '0;
    end else begin : g_inner
      assign nk = cell_key[i+1];
      assign np = cell_pay[i+1];
    end

    siq_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .valid        (valid[i]),
      .shift_in     (shift[i]),
      .prev_key     (pk),
      .prev_payload (pp),
      .next_key     (nk),
      .next_payload (np),
      .shift_out    (shift[i+1]),
      .key_r        (cell_key[i]),
      .payload_r    (cell_pay[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load with the item, hold while stalled.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r <= status_nxt;
      okey_r   <= okey_nxt;
      opay_r   <= opay_nxt;
      ofill_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, 5'(ofill_r), ofill_r == '0, opay_r, okey_r};

  // Fill count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  // An accepted insert that is not dropped grows the queue by one.
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && ctl.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow queue");

  // A remove on an empty queue reports zero key and payload.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == siq_pkg::ST_EMPTY |-> okey_r == '0 && opay_r == '0)
    else $error("empty remove carried data");

endmodule
